/* hdl/i2c_temp_sensor_poller_top_macros.svh */
// assertion macros for the poller top level
`ifndef I2C_TEMP_SENSOR_POLLER_TOP_MACROS_SVH
`define I2C_TEMP_SENSOR_POLLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// condition in this cycle implies consequence in this cycle
`define ITSP_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define ITSP_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`else

`define ITSP_ASSERT_NOW(label, clk, rst, cond, cons, msg)
`define ITSP_ASSERT_NEXT(label, clk, rst, cond, cons, msg)

`endif

`endif

/* hdl/itsp_pkg.sv */
// shared types, codes and the temperature decode for the sensor poller
package itsp_pkg;

   // request kinds
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_POLL  = 2'd1;
   localparam logic [1:0] REQ_DONE  = 2'd2;

   // sensor register numbers
   localparam logic [2:0] REG_NONE  = 3'd0;
   localparam logic [2:0] REG_TEMP  = 3'd5;
   localparam logic [2:0] REG_MAKER = 3'd6;
   localparam logic [2:0] REG_PART  = 3'd7;

   // status codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_BUS   = 3'd1;
   localparam logic [2:0] ERR_MAKER = 3'd2;
   localparam logic [2:0] ERR_PART  = 3'd3;
   localparam logic [2:0] ERR_DOWN  = 3'd4;

   // csr indexes
   localparam logic [1:0] CSR_RETRY = 2'd0;
   localparam logic [1:0] CSR_POLL  = 2'd1;
   localparam logic [1:0] CSR_MAKER = 2'd2;
   localparam logic [1:0] CSR_PART  = 2'd3;

   // csr reset values
   localparam logic [15:0] RETRY_RESET = 16'd1000;
   localparam logic [15:0] POLL_RESET  = 16'd100;
   localparam logic [15:0] MAKER_RESET = 16'h0054;
   localparam logic [15:0] PART_RESET  = 16'h0400;

   // held temperature after reset or start
   localparam logic [15:0] TEMP_RESET = 16'd250;

   typedef struct packed {
      logic [15:0] retry_period_ms;
      logic [15:0] poll_period_ms;
      logic [15:0] expected_maker_id;
      logic [15:0] expected_part_id;
   } itsp_cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic        read_ok;
      logic [15:0] read_word;
      logic [7:0]  bus_error_code;
   } itsp_req_type;

   typedef struct packed {
      logic               issue_read;
      logic [2:0]         read_register;
      logic               call_done;
      logic               call_ok;
      logic signed [15:0] ambient_cdeg;
      logic               have_temp;
      logic               sensor_up;
      logic [2:0]         error_code;
      logic [7:0]         bus_status;
      logic [15:0]        seen_maker_id;
      logic [15:0]        seen_part_id;
   } itsp_rsp_type;

   // raw word to hundredths of a degree: (low 12 bits * 100) / 16, sign bit 12
   function automatic logic [15:0] decode_temp(input logic [15:0] raw);
      logic [18:0] prod;
      logic [15:0] mag;
      begin
         prod = {7'd0, raw[11:0]} * 19'd100;
         mag  = {1'b0, prod[18:4]};
         decode_temp = raw[12] ? (mag - 16'd25600) : mag;
      end
   endfunction

endpackage

/* hdl/itsp_csr.sv */
// configuration registers behind the apb-style port
module itsp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output itsp_pkg::itsp_cfg_type cfg
);
   import itsp_pkg::*;

   itsp_cfg_type cfg_ff;
   logic         wr_en;
   logic [1:0]   idx;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_period_ms   <= RETRY_RESET;
         cfg_ff.poll_period_ms    <= POLL_RESET;
         cfg_ff.expected_maker_id <= MAKER_RESET;
         cfg_ff.expected_part_id  <= PART_RESET;
      end else if (wr_en) begin
         case (idx)
            CSR_RETRY: cfg_ff.retry_period_ms   <= pwdata[15:0];
            CSR_POLL:  cfg_ff.poll_period_ms    <= pwdata[15:0];
            CSR_MAKER: cfg_ff.expected_maker_id <= pwdata[15:0];
            CSR_PART:  cfg_ff.expected_part_id  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         CSR_RETRY: prdata = {16'd0, cfg_ff.retry_period_ms};
         CSR_POLL:  prdata = {16'd0, cfg_ff.poll_period_ms};
         CSR_MAKER: prdata = {16'd0, cfg_ff.expected_maker_id};
         CSR_PART:  prdata = {16'd0, cfg_ff.expected_part_id};
         default:   prdata = 32'd0;
      endcase
   end

endmodule

/* hdl/itsp_core.sv */
// sensor state, per-beat decision and the result register
module itsp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  itsp_pkg::itsp_cfg_type cfg,
   input  logic                   in_valid,
   input  itsp_pkg::itsp_req_type in_beat,
   input  logic                   rsp_stall,
   output logic                   take,
   output logic                   rsp_valid,
   output itsp_pkg::itsp_rsp_type rsp_beat
);
   import itsp_pkg::*;

   // phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_MAKER = 2'd1;
   localparam logic [1:0] PH_PART  = 2'd2;
   localparam logic [1:0] PH_TEMP  = 2'd3;

   logic [1:0]  phase_ff,     phase_in;
   logic        pend_poll_ff, pend_poll_in;
   logic [31:0] pend_time_ff, pend_time_in;
   logic [31:0] last_att_ff,  last_att_in;
   logic [31:0] last_upd_ff,  last_upd_in;
   logic [15:0] temp_ff,      temp_in;
   logic [15:0] maker_ff,     maker_in;
   logic [15:0] part_ff,      part_in;
   logic        up_ff,        up_in;
   logic        ready_ff,     ready_in;
   logic [2:0]  err_ff,       err_in;
   logic [7:0]  bus_ff,       bus_in;

   logic         rsp_valid_ff;
   itsp_rsp_type rsp_ff, rsp_in;

   logic        issue, done, ok, probe_end, passed;
   logic [2:0]  rd_reg;
   logic [31:0] since_att, since_upd;

   // the result register frees up when empty or taken this cycle
   assign take      = in_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   assign since_att = in_beat.now_ms - last_att_ff;
   assign since_upd = in_beat.now_ms - last_upd_ff;

   // next state and result for one beat
   always_comb begin
      phase_in     = phase_ff;
      pend_poll_in = pend_poll_ff;
      pend_time_in = pend_time_ff;
      last_att_in  = last_att_ff;
      last_upd_in  = last_upd_ff;
      temp_in      = temp_ff;
      maker_in     = maker_ff;
      part_in      = part_ff;
      up_in        = up_ff;
      ready_in     = ready_ff;
      err_in       = err_ff;
      bus_in       = bus_ff;
      issue        = 1'b0;
      rd_reg       = REG_NONE;
      done         = 1'b0;
      ok           = 1'b0;
      probe_end    = 1'b0;
      passed       = 1'b0;

      case (in_beat.req_type)
         REQ_START: begin
            last_upd_in  = 32'd0;
            last_att_in  = in_beat.now_ms;
            temp_in      = TEMP_RESET;
            maker_in     = 16'd0;
            part_in      = 16'd0;
            up_in        = 1'b0;
            ready_in     = 1'b0;
            err_in       = ERR_DOWN;
            bus_in       = 8'd0;
            pend_poll_in = 1'b0;
            phase_in     = PH_MAKER;
            issue        = 1'b1;
            rd_reg       = REG_MAKER;
         end
         REQ_POLL: begin
            if (phase_ff == PH_IDLE) begin
               if (!up_ff) begin
                  // sensor down: retry the probe when the retry period is up
                  if (since_att >= {16'd0, cfg.retry_period_ms}) begin
                     last_att_in  = in_beat.now_ms;
                     bus_in       = 8'd0;
                     pend_poll_in = 1'b1;
                     phase_in     = PH_MAKER;
                     issue        = 1'b1;
                     rd_reg       = REG_MAKER;
                  end else begin
                     err_in = ERR_DOWN;
                     done   = 1'b1;
                  end
               end else if (since_upd < {16'd0, cfg.poll_period_ms}) begin
                  done = 1'b1;
                  ok   = ready_ff;
               end else begin
                  pend_time_in = in_beat.now_ms;
                  pend_poll_in = 1'b1;
                  phase_in     = PH_TEMP;
                  issue        = 1'b1;
                  rd_reg       = REG_TEMP;
               end
            end
         end
         REQ_DONE: begin
            if (phase_ff inside {PH_MAKER, PH_PART}) begin
               // probe reads
               if (!in_beat.read_ok) begin
                  up_in     = 1'b0;
                  err_in    = ERR_BUS;
                  bus_in    = in_beat.bus_error_code;
                  probe_end = 1'b1;
               end else if (phase_ff == PH_MAKER) begin
                  maker_in = in_beat.read_word;
                  if (in_beat.read_word != cfg.expected_maker_id) begin
                     up_in     = 1'b0;
                     err_in    = ERR_MAKER;
                     probe_end = 1'b1;
                  end else begin
                     phase_in = PH_PART;
                     issue    = 1'b1;
                     rd_reg   = REG_PART;
                  end
               end else begin
                  part_in = in_beat.read_word;
                  if (in_beat.read_word != cfg.expected_part_id) begin
                     up_in     = 1'b0;
                     err_in    = ERR_PART;
                     probe_end = 1'b1;
                  end else begin
                     up_in     = 1'b1;
                     err_in    = ERR_NONE;
                     bus_in    = 8'd0;
                     probe_end = 1'b1;
                     passed    = 1'b1;
                  end
               end
            end else if (phase_ff == PH_TEMP) begin
               // temperature read
               phase_in = PH_IDLE;
               done     = 1'b1;
               if (!in_beat.read_ok) begin
                  ready_in = 1'b0;
                  up_in    = 1'b0;
                  err_in   = ERR_BUS;
                  bus_in   = in_beat.bus_error_code;
               end else begin
                  last_upd_in = pend_time_ff;
                  temp_in     = decode_temp(in_beat.read_word);
                  ready_in    = 1'b1;
                  err_in      = ERR_NONE;
                  bus_in      = 8'd0;
                  ok          = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // probe finished: a probe started by a poll always ends with the down code and a failed call
      if (probe_end) begin
         phase_in = PH_IDLE;
         done     = 1'b1;
         if (pend_poll_ff) begin
            err_in = ERR_DOWN;
            ok     = 1'b0;
         end else begin
            ok = passed;
         end
      end

      rsp_in.issue_read    = issue;
      rsp_in.read_register = rd_reg;
      rsp_in.call_done     = done;
      rsp_in.call_ok       = ok;
      rsp_in.ambient_cdeg  = temp_in;
      rsp_in.have_temp     = ready_in;
      rsp_in.sensor_up     = up_in;
      rsp_in.error_code    = err_in;
      rsp_in.bus_status    = bus_in;
      rsp_in.seen_maker_id = maker_in;
      rsp_in.seen_part_id  = part_in;
   end

   // sensor state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pend_poll_ff <= 1'b0;
         pend_time_ff <= 32'd0;
         last_att_ff  <= 32'd0;
         last_upd_ff  <= 32'd0;
         temp_ff      <= TEMP_RESET;
         maker_ff     <= 16'd0;
         part_ff      <= 16'd0;
         up_ff        <= 1'b0;
         ready_ff     <= 1'b0;
         err_ff       <= ERR_DOWN;
         bus_ff       <= 8'd0;
      end else if (take) begin
         phase_ff     <= phase_in;
         pend_poll_ff <= pend_poll_in;
         pend_time_ff <= pend_time_in;
         last_att_ff  <= last_att_in;
         last_upd_ff  <= last_upd_in;
         temp_ff      <= temp_in;
         maker_ff     <= maker_in;
         part_ff      <= part_in;
         up_ff        <= up_in;
         ready_ff     <= ready_in;
         err_ff       <= err_in;
         bus_ff       <= bus_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hdl/i2c_temp_sensor_poller_top.sv */
// top level of the temperature sensor poller
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  type, time, read completion fields
//   rsp      out        rsp_valid/rsp_stall  read request, call outcome, status
//   csr      in         apb-style psel/...   four 16-bit registers at 0x0..0xc
//
// one beat per cycle while rsp_stall is low; a beat goes through the input
// register and then the result register, whose valid flag marks its result
// while a finished result waits, an empty input register still takes one beat
// reset clears the state to not-initialized with no read outstanding
// rsp_stall holds the result register, then the input register, then req_stall
module i2c_temp_sensor_poller_top (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [31:0]        req_now_ms,
   input  logic               req_read_ok,
   input  logic [15:0]        req_read_word,
   input  logic [7:0]         req_bus_error_code,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_issue_read,
   output logic [2:0]         rsp_read_register,
   output logic               rsp_call_done,
   output logic               rsp_call_ok,
   output logic signed [15:0] rsp_ambient_cdeg,
   output logic               rsp_have_temp,
   output logic               rsp_sensor_up,
   output logic [2:0]         rsp_error_code,
   output logic [7:0]         rsp_bus_status,
   output logic [15:0]        rsp_seen_maker_id,
   output logic [15:0]        rsp_seen_part_id,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import itsp_pkg::*;

   `include "i2c_temp_sensor_poller_top_macros.svh"

   itsp_cfg_type cfg;
   itsp_req_type in_beat_ff;
   logic         in_valid_ff;
   logic         take;
   itsp_rsp_type rsp_beat;

   // configuration registers
   itsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register: refills when empty or when its beat moves on
   assign req_stall = in_valid_ff && !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_beat_ff.req_type       <= req_type;
         in_beat_ff.now_ms         <= req_now_ms;
         in_beat_ff.read_ok        <= req_read_ok;
         in_beat_ff.read_word      <= req_read_word;
         in_beat_ff.bus_error_code <= req_bus_error_code;
      end
   end

   // decision logic and result register
   itsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_beat   (in_beat_ff),
      .rsp_stall (rsp_stall),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

   // result fields
   assign rsp_issue_read    = rsp_beat.issue_read;
   assign rsp_read_register = rsp_beat.read_register;
   assign rsp_call_done     = rsp_beat.call_done;
   assign rsp_call_ok       = rsp_beat.call_ok;
   assign rsp_ambient_cdeg  = rsp_beat.ambient_cdeg;
   assign rsp_have_temp     = rsp_beat.have_temp;
   assign rsp_sensor_up     = rsp_beat.sensor_up;
   assign rsp_error_code    = rsp_beat.error_code;
   assign rsp_bus_status    = rsp_beat.bus_status;
   assign rsp_seen_maker_id = rsp_beat.seen_maker_id;
   assign rsp_seen_part_id  = rsp_beat.seen_part_id;

   // checks
   `ITSP_ASSERT_NOW(a_issue_not_done, clock, reset, rsp_valid && rsp_issue_read, !rsp_call_done, "request and done")
   `ITSP_ASSERT_NOW(a_reg_only_on_issue, clock, reset, rsp_valid && !rsp_issue_read, rsp_read_register == REG_NONE, "stray reg")
   `ITSP_ASSERT_NOW(a_up_status, clock, reset, rsp_valid && rsp_sensor_up, rsp_error_code == ERR_NONE || rsp_error_code == ERR_DOWN, "up failed")
   `ITSP_ASSERT_NEXT(a_stall_holds_input, clock, reset, req_stall, in_valid_ff, "stalled beat lost")

endmodule
